>>> sv/lkd_pkg.sv
// Package: shared types, constants and state codes for the keystream byte descrambler.
package lkd_pkg;

   localparam int KEY_W           = 32;
   localparam int BYTE_W          = 8;
   localparam int ENTRY_W         = 15;
   localparam int POS_SPAN        = 256;
   localparam int DEF_TABLE_DEPTH = 256;

   localparam logic [KEY_W-1:0] LCG_MUL   = 32'h0003_43FD;
   localparam logic [KEY_W-1:0] LCG_ADD   = 32'h0026_9EC3;
   localparam logic [KEY_W-1:0] WORD_MASK = 32'h0000_7FFF;

   typedef struct packed {
      logic [BYTE_W-1:0] cipher_byte;
      logic [BYTE_W-1:0] stream_position;
      logic              last_in_buffer;
   } lkd_req_type;

   typedef struct packed {
      logic [BYTE_W-1:0] plain_byte;
      logic              last_out;
   } lkd_rsp_type;

   typedef enum logic [1:0] {
      ST_STALE,
      ST_BUILD,
      ST_RUN
   } lkd_state_type;

   typedef struct packed {
      logic seed_load;
      logic build_step;
      logic lookup;
      logic out_load;
   } lkd_cmd_type;

   typedef struct packed {
      logic build_last;
   } lkd_sts_type;

endpackage

>>> sv/lkd_ctrl.sv
// Controller: table build sequencer and lookup pipeline valid tracking.
module lkd_ctrl
   import lkd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        csr_write_en,
   input  lkd_sts_type sts,
   output lkd_cmd_type cmd
);

   lkd_state_type state_ff, state_in;
   logic          s1_valid_ff, s1_valid_in;
   logic          out_valid_ff, out_valid_in;
   logic          out_free;
   logic          s1_move;
   logic          accept;

   // next state
   always_comb begin
      case (state_ff)
         ST_STALE: state_in = ST_BUILD;
         ST_BUILD: state_in = sts.build_last ? ST_RUN : ST_BUILD;
         ST_RUN:   state_in = ST_RUN;
         default:  state_in = ST_STALE;
      endcase
      // a new key makes the table stale
      if (csr_write_en) begin
         state_in = ST_STALE;
      end
   end

   // pipeline flow
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = !((state_ff == ST_RUN) && (!s1_valid_ff || out_free));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = out_valid_ff;

   // outputs
   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_STALE: cmd.seed_load  = 1'b1;
         ST_BUILD: cmd.build_step = 1'b1;
         ST_RUN: begin
            cmd.lookup   = accept;
            cmd.out_load = s1_move;
         end
         default: cmd = '0;
      endcase
   end

   always_comb begin
      s1_valid_in  = accept ? 1'b1 : (s1_move ? 1'b0 : s1_valid_ff);
      out_valid_in = s1_move ? 1'b1 : (rsp_stall ? out_valid_ff : 1'b0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_STALE;
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   a_key_write_stale: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> state_ff == ST_STALE)
      else $error("key write did not mark the table stale");

   a_stale_to_build: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_STALE && !csr_write_en) |=> state_ff == ST_BUILD)
      else $error("stale table did not start a build");

   a_build_finish: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_BUILD && sts.build_last && !csr_write_en) |=> state_ff == ST_RUN)
      else $error("build did not finish at the last entry");

   a_lookup_from_accept: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_valid_ff) |-> $past(req_valid && !req_stall))
      else $error("lookup stage filled without an accepted beat");

endmodule

>>> sv/lkd_dpath.sv
// Datapath: key register, LCG stepper, keystream table and byte decode.
module lkd_dpath
   import lkd_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_write_en,
   input  logic [KEY_W-1:0]  csr_write_data,
   input  lkd_req_type       req_data,
   output lkd_rsp_type       rsp_data,
   input  lkd_cmd_type       cmd,
   output lkd_sts_type       sts
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   logic [KEY_W-1:0]   key_ff;
   logic [KEY_W-1:0]   x_ff;
   logic [KEY_W-1:0]   x_step;
   logic [IDX_W-1:0]   idx_ff;
   logic [ENTRY_W-1:0] entry;
   logic [ENTRY_W-1:0] table_mem [TABLE_DEPTH];
   logic [ENTRY_W-1:0] rd_ff;
   logic [BYTE_W-1:0]  cipher_ff;
   logic               last_ff;
   logic [BYTE_W-1:0]  plain;
   lkd_rsp_type        rsp_ff;
   logic [IDX_W-1:0]   pos_map [POS_SPAN];

   // position to table index, folded at elaboration
   for (genvar g = 0; g < POS_SPAN; g++) begin : g_pos_map
      assign pos_map[g] = IDX_W'(g % TABLE_DEPTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff <= '0;
      end else if (csr_write_en) begin
         key_ff <= csr_write_data;
      end
   end

   assign x_step = x_ff * LCG_MUL + LCG_ADD;
   assign entry  = ENTRY_W'((x_step >> 16) & WORD_MASK);
   assign sts.build_last = (idx_ff == IDX_W'(TABLE_DEPTH - 1));

   always_ff @(posedge clock) begin
      if (cmd.seed_load) begin
         x_ff   <= key_ff;
         idx_ff <= '0;
      end else if (cmd.build_step) begin
         x_ff   <= x_step;
         idx_ff <= idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.build_step) begin
         table_mem[idx_ff] <= entry;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.lookup) begin
         rd_ff     <= table_mem[pos_map[req_data.stream_position]];
         cipher_ff <= req_data.cipher_byte;
         last_ff   <= req_data.last_in_buffer;
      end
   end

   // xor with the low byte, then subtract the upper seven bits
   assign plain = (cipher_ff ^ rd_ff[7:0]) - {1'b0, rd_ff[14:8]};

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_ff.plain_byte <= plain;
         rsp_ff.last_out   <= last_ff;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

>>> sv/lcg_keystream_byte_descrambler.sv
// Top level: LCG keystream byte descrambler, controller plus datapath.
//
//   channel  direction  handshake               beat payload
//   req_     in         req_valid / req_stall   lkd_req_type (cipher, position, last)
//   rsp_     out        rsp_valid / rsp_stall   lkd_rsp_type (plain, last)
//   csr_     in         csr_write_en            32-bit scramble key, no read-back
//
// After reset, and after every key write, the block rebuilds the keystream
// table: a seed load, then TABLE_DEPTH build steps, one LCG step and one
// table write each, with req_stall held high the whole time.
// Once built, one beat is taken per cycle while rsp_stall is low; a beat
// passes the table read, then the output register, on its way to rsp_valid.
// Reset is synchronous, active high, and leaves key 0 with a stale table.
// A stalled result holds in the output register while one more beat
// finishes its table read behind it; only then does req_stall rise.
module lcg_keystream_byte_descrambler
   import lkd_pkg::*;
#(
   parameter int TABLE_DEPTH = DEF_TABLE_DEPTH
)
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lkd_req_type      req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lkd_rsp_type      rsp_data,
   input  logic             csr_write_en,
   input  logic [KEY_W-1:0] csr_write_data
);

   lkd_cmd_type cmd;
   lkd_sts_type sts;

   // sequencer: build the table, then advance beats through the lookup
   lkd_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .csr_write_en (csr_write_en),
      .sts          (sts),
      .cmd          (cmd)
   );

   // key, generator, table memory and the xor-subtract decode
   lkd_dpath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dpath (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_data       (req_data),
      .rsp_data       (rsp_data),
      .cmd            (cmd),
      .sts            (sts)
   );

endmodule
